@@ design/newline_line_framer_macros.svh @@
// Assertion macros shared by the line framer RTL.
`ifndef NEWLINE_LINE_FRAMER_MACROS_SVH
`define NEWLINE_LINE_FRAMER_MACROS_SVH

`ifndef NO_ASSERTIONS

// Checked on every edge outside reset.
`define NLF_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("line framer check failed");

// Checked on every edge, reset included.
`define NLF_ASSERT_ALWAYS(lbl, prop) \
  lbl: assert property (@(posedge clk) prop) \
    else $error("line framer reset check failed");

`else

`define NLF_ASSERT(lbl, prop)
`define NLF_ASSERT_ALWAYS(lbl, prop)

`endif

`endif

@@ design/nlf_pkg.sv @@
// Shared constants, codes and types for the newline line framer.
package nlf_pkg;

  localparam int DEPTH   = 1024;
  localparam int PTR_W   = $clog2(DEPTH);
  localparam int CNT_W   = PTR_W + 1;
  localparam int LEN_W   = 16;
  localparam int CMP_W   = (CNT_W > LEN_W) ? CNT_W : LEN_W;
  localparam int BYTE_W  = 8;
  localparam int RAW_W   = 10;
  localparam int CAP_W   = 7;
  localparam int LIM_W   = 6;
  localparam int SCMP_W  = (PTR_W > LIM_W) ? PTR_W : LIM_W;

  localparam logic [CAP_W-1:0]  CAP_LIMIT = CAP_W'(64);
  localparam logic [BYTE_W-1:0] NL_CHAR   = 8'h0A;

  // input action codes
  localparam logic [1:0] ACT_CHUNK   = 2'd0;
  localparam logic [1:0] ACT_BYTE    = 2'd1;
  localparam logic [1:0] ACT_EXTRACT = 2'd2;

  // result kind codes
  localparam logic [1:0] KIND_STATUS = 2'd0;
  localparam logic [1:0] KIND_BYTE   = 2'd1;
  localparam logic [1:0] KIND_END    = 2'd2;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_RD,
    ST_CHK
  } nlf_state_t;

endpackage

@@ design/nlf_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
module nlf_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule

@@ design/newline_line_framer.sv @@
// Newline line framer: circular byte store, chunk admission and line extraction.
// A chunk-start transaction gives one status result, accepted only if the whole
// chunk fits in the free space; data bytes of an accepted chunk go into a
// 1024-byte circular store and never give a result. An extract transaction
// scans the store from the oldest byte through the single read port of the
// byte RAM, an address and then the registered read data for each byte,
// emitting up to min(line_capacity, 64) - 1 line bytes and then an end
// result carrying the untruncated length. A failing extract gives only an
// end result; an extract also waits out any output stall. The input is not
// ready during an extract or while a result is held and not taken. No
// clearing pass runs after reset: only written store entries are read.
module newline_line_framer (
  input  logic        clk,
  input  logic        rst_n,
  // configuration
  input  logic        cfg_wr_en,
  input  logic [6:0]  cfg_wr_data,   // line_capacity
  // input stream
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [23:0] in_tdata,      // [7:0] data_byte, [23:8] chunk_length
  input  logic [1:0]  in_tuser,      // action
  // result stream
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [23:0] out_tdata,     // [0] ok, [8:1] line_byte, [18:9] line_len,
                                     // [23:19] zero
  output logic [1:0]  out_tuser,     // kind
  output logic        out_tlast
);

  `include "newline_line_framer_macros.svh"

  localparam logic [nlf_pkg::CNT_W-1:0] DEPTH_C = nlf_pkg::CNT_W'(nlf_pkg::DEPTH);

  nlf_pkg::nlf_state_t st_r, st_nxt;

  logic [nlf_pkg::PTR_W-1:0]  head_r, head_nxt;
  logic [nlf_pkg::CNT_W-1:0]  fill_r, fill_nxt;
  logic [nlf_pkg::CNT_W-1:0]  nl_cnt_r, nl_cnt_nxt;
  logic [nlf_pkg::LEN_W-1:0]  left_r, left_nxt;
  logic                       acc_r, acc_nxt;
  logic [nlf_pkg::CAP_W-1:0]  cap_r;
  logic [nlf_pkg::PTR_W-1:0]  rd_ptr_r, rd_ptr_nxt;
  logic [nlf_pkg::PTR_W-1:0]  scan_r, scan_nxt;
  logic [nlf_pkg::LIM_W-1:0]  lim_r, lim_nxt;

  logic                       out_valid_r, out_valid_nxt;
  logic [1:0]                 out_kind_r;
  logic                       out_ok_r;
  logic [nlf_pkg::BYTE_W-1:0] out_byte_r;
  logic [nlf_pkg::RAW_W-1:0]  out_raw_r;
  logic                       out_last_r;

  logic                       load;
  logic [1:0]                 ld_kind;
  logic                       ld_ok;
  logic [nlf_pkg::BYTE_W-1:0] ld_byte;
  logic [nlf_pkg::RAW_W-1:0]  ld_raw;
  logic                       ld_last;

  logic                       out_free;
  logic [nlf_pkg::BYTE_W-1:0] in_byte;
  logic [nlf_pkg::LEN_W-1:0]  in_len;
  logic [nlf_pkg::CMP_W-1:0]  free_space;
  logic                       chunk_fits;
  logic [nlf_pkg::CAP_W-1:0]  cap_eff;
  logic [nlf_pkg::CNT_W-1:0]  wr_sum;
  logic [nlf_pkg::CNT_W-1:0]  wr_wrap;
  logic [nlf_pkg::CNT_W-1:0]  ptr_sum;
  logic [nlf_pkg::PTR_W-1:0]  ptr_inc;
  logic                       ram_we;
  logic [nlf_pkg::BYTE_W-1:0] rd_data;
  logic                       nl_hit;
  logic                       emit_byte;

  assign in_byte  = in_tdata[7:0];
  assign in_len   = in_tdata[23:8];
  assign out_free = !out_valid_r || out_tready;

  assign free_space = nlf_pkg::CMP_W'(DEPTH_C - fill_r);
  assign chunk_fits = nlf_pkg::CMP_W'(in_len) <= free_space;
  assign cap_eff    = (cap_r > nlf_pkg::CAP_LIMIT) ? nlf_pkg::CAP_LIMIT : cap_r;

  // append address: head + fill, wrapped once
  assign wr_sum  = nlf_pkg::CNT_W'(head_r) + fill_r;
  assign wr_wrap = (wr_sum >= DEPTH_C) ? wr_sum - DEPTH_C : wr_sum;

  assign ptr_sum = nlf_pkg::CNT_W'(rd_ptr_r) + nlf_pkg::CNT_W'(1);
  assign ptr_inc = (ptr_sum == DEPTH_C) ? '0 : ptr_sum[nlf_pkg::PTR_W-1:0];

  assign nl_hit    = (rd_data == nlf_pkg::NL_CHAR);
  assign emit_byte = nlf_pkg::SCMP_W'(scan_r) < nlf_pkg::SCMP_W'(lim_r);

  nlf_ram #(
    .WIDTH (nlf_pkg::BYTE_W),
    .DEPTH (nlf_pkg::DEPTH)
  ) u_store (
    .clk     (clk),
    .wr_en   (ram_we),
    .wr_addr (wr_wrap[nlf_pkg::PTR_W-1:0]),
    .wr_data (in_byte),
    .rd_addr (rd_ptr_r),
    .rd_data (rd_data)
  );

  always_comb begin
    st_nxt     = st_r;
    head_nxt   = head_r;
    fill_nxt   = fill_r;
    nl_cnt_nxt = nl_cnt_r;
    left_nxt   = left_r;
    acc_nxt    = acc_r;
    rd_ptr_nxt = rd_ptr_r;
    scan_nxt   = scan_r;
    lim_nxt    = lim_r;
    ram_we     = 1'b0;
    load       = 1'b0;
    ld_kind    = nlf_pkg::KIND_STATUS;
    ld_ok      = 1'b0;
    ld_byte    = '0;
    ld_raw     = '0;
    ld_last    = 1'b0;
    in_tready  = (st_r == nlf_pkg::ST_IDLE) && out_free;

    case (st_r)
      nlf_pkg::ST_IDLE: begin
        if (in_tvalid && in_tready) begin
          case (in_tuser)
            nlf_pkg::ACT_CHUNK: begin
              acc_nxt  = chunk_fits;
              left_nxt = in_len;
              load     = 1'b1;
              ld_kind  = nlf_pkg::KIND_STATUS;
              ld_ok    = chunk_fits;
              ld_last  = 1'b1;
            end
            nlf_pkg::ACT_BYTE: begin
              if (left_r != '0) begin
                left_nxt = left_r - nlf_pkg::LEN_W'(1);
                if (acc_r && fill_r < DEPTH_C) begin
                  ram_we   = 1'b1;
                  fill_nxt = fill_r + nlf_pkg::CNT_W'(1);
                  if (in_byte == nlf_pkg::NL_CHAR) begin
                    nl_cnt_nxt = nl_cnt_r + nlf_pkg::CNT_W'(1);
                  end
                end
              end
            end
            nlf_pkg::ACT_EXTRACT: begin
              if (cap_eff == '0 || nl_cnt_r == '0) begin
                load    = 1'b1;
                ld_kind = nlf_pkg::KIND_END;
                ld_last = 1'b1;
              end else begin
                lim_nxt    = nlf_pkg::LIM_W'(cap_eff - nlf_pkg::CAP_W'(1));
                scan_nxt   = '0;
                rd_ptr_nxt = head_r;
                st_nxt     = nlf_pkg::ST_RD;
              end
            end
            default: ;
          endcase
        end
      end
      nlf_pkg::ST_RD: begin
        st_nxt = nlf_pkg::ST_CHK;
      end
      nlf_pkg::ST_CHK: begin
        if (nl_hit) begin
          if (out_free) begin
            load       = 1'b1;
            ld_kind    = nlf_pkg::KIND_END;
            ld_ok      = 1'b1;
            ld_raw     = nlf_pkg::RAW_W'(scan_r);
            ld_last    = 1'b1;
            head_nxt   = ptr_inc;
            fill_nxt   = fill_r - nlf_pkg::CNT_W'(scan_r) - nlf_pkg::CNT_W'(1);
            nl_cnt_nxt = nl_cnt_r - nlf_pkg::CNT_W'(1);
            st_nxt     = nlf_pkg::ST_IDLE;
          end
        end else if (!emit_byte || out_free) begin
          // past the truncation point the scan runs on without output
          if (emit_byte) begin
            load    = 1'b1;
            ld_kind = nlf_pkg::KIND_BYTE;
            ld_byte = rd_data;
          end
          scan_nxt   = scan_r + nlf_pkg::PTR_W'(1);
          rd_ptr_nxt = ptr_inc;
          st_nxt     = nlf_pkg::ST_RD;
        end
      end
      default: begin
        st_nxt = nlf_pkg::ST_IDLE;
      end
    endcase

    out_valid_nxt = load || (out_valid_r && !out_tready);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= nlf_pkg::ST_IDLE;
    end else begin
      st_r <= st_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      head_r      <= '0;
      fill_r      <= '0;
      nl_cnt_r    <= '0;
      left_r      <= '0;
      acc_r       <= 1'b0;
      cap_r       <= nlf_pkg::CAP_LIMIT;
      out_valid_r <= 1'b0;
    end else begin
      head_r      <= head_nxt;
      fill_r      <= fill_nxt;
      nl_cnt_r    <= nl_cnt_nxt;
      left_r      <= left_nxt;
      acc_r       <= acc_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_wr_en) begin
        cap_r <= cfg_wr_data;
      end
    end
  end

  // scan state and result payload
  always_ff @(posedge clk) begin
    rd_ptr_r <= rd_ptr_nxt;
    scan_r   <= scan_nxt;
    lim_r    <= lim_nxt;
    if (load) begin
      out_kind_r <= ld_kind;
      out_ok_r   <= ld_ok;
      out_byte_r <= ld_byte;
      out_raw_r  <= ld_raw;
      out_last_r <= ld_last;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tuser  = out_kind_r;
  assign out_tlast  = out_last_r;
  assign out_tdata  = {5'd0, out_raw_r, out_byte_r, out_ok_r};

  `NLF_ASSERT(a_fill_bound, fill_r <= DEPTH_C)
  `NLF_ASSERT(a_nl_within_fill, nl_cnt_r <= fill_r)
  `NLF_ASSERT(a_scan_in_store,
    (st_r != nlf_pkg::ST_IDLE) |-> (nlf_pkg::CNT_W'(scan_r) < fill_r))
  `NLF_ASSERT(a_line_removed,
    (st_r == nlf_pkg::ST_CHK && nl_hit && out_free)
      |=> (nl_cnt_r == $past(nl_cnt_r) - nlf_pkg::CNT_W'(1)))
  `NLF_ASSERT_ALWAYS(a_reset_quiet, !rst_n |=> !out_tvalid)

endmodule
